// ----- design/lcmc_pkg.sv -----
package lcmc_pkg;

  localparam int FIELD_W           = 64;
  localparam int STATUS_W          = 2;
  localparam int OPERAND_WIDTH_DEF = 64;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ZERO_B   = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

// ----- design/lcmc_addsub.sv -----
module lcmc_addsub #(
  parameter int W = lcmc_pkg::OPERAND_WIDTH_DEF
) (
  input  logic [W:0]            op_a,
  input  logic [W:0]            op_b,
  input  lcmc_pkg::alu_op_t     op,
  output logic [W:0]            res
);
  import lcmc_pkg::*;

  // top bit is carry out on add, borrow on subtract
  always_comb begin
    unique case (op)
      ALU_ADD: res = op_a + op_b;
      ALU_SUB: res = op_a - op_b;
      default: res = op_a - op_b;
    endcase
  end

endmodule

// ----- design/lcmc_ctrl.sv -----
module lcmc_ctrl #(
  parameter int W = lcmc_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [W-1:0]          opa,
  input  logic [W-1:0]          opb,
  output logic                  busy,
  output logic                  res_valid,
  output logic [W-1:0]          res_value,
  output lcmc_pkg::status_t     res_status,
  output logic [W:0]            alu_a,
  output logic [W:0]            alu_b,
  output lcmc_pkg::alu_op_t     alu_op,
  input  logic [W:0]            alu_res
);
  import lcmc_pkg::*;

  localparam int CNT_W = $clog2(W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TWOS,
    S_GCD,
    S_DIV,
    S_MUL
  } state_t;

  state_t        state_r, state_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  a_r, a_nxt;      // operand a, then quotient bits
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  rem_r, rem_nxt;  // division remainder, then product accumulator
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          valid_r, valid_nxt;
  logic [W-1:0]  value_r, value_nxt;
  status_t       status_r, status_nxt;
  logic [W:0]    shifted;
  logic          ovf_step;

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    valid_nxt  = 1'b0;
    value_nxt  = value_r;
    status_nxt = status_r;
    alu_a      = {1'b0, x_r};
    alu_b      = {1'b0, y_r};
    alu_op     = ALU_SUB;
    shifted    = {rem_r, a_r[W-1]};
    ovf_step   = ovf_r | rem_r[W-1] | alu_res[W];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (opb == '0) begin
            valid_nxt  = 1'b1;
            value_nxt  = '0;
            status_nxt = ST_ZERO_B;
          end else if (opa == '0) begin
            valid_nxt  = 1'b1;
            value_nxt  = '0;
            status_nxt = ST_OK;
          end else begin
            x_nxt     = opa;
            y_nxt     = opb;
            a_nxt     = opa;
            b_nxt     = opb;
            state_nxt = S_TWOS;
          end
        end
      end
      // strip common factors of two; a is shifted along so a/gcd = a_r/odd part
      S_TWOS: begin
        if (x_r[0] | y_r[0]) begin
          state_nxt = S_GCD;
        end else begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          a_nxt = a_r >> 1;
        end
      end
      S_GCD: begin
        if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (alu_res == '0) begin
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(W - 1);
          state_nxt = S_DIV;
        end else if (alu_res[W]) begin
          // keep x the larger one
          x_nxt = y_r;
          y_nxt = x_r;
        end else begin
          x_nxt = {1'b0, alu_res[W-1:1]};
        end
      end
      // restoring division a_r / x_r, one quotient bit per cycle
      S_DIV: begin
        alu_a   = shifted;
        alu_b   = {1'b0, x_r};
        alu_op  = ALU_SUB;
        a_nxt   = {a_r[W-2:0], ~alu_res[W]};
        rem_nxt = alu_res[W] ? shifted[W-1:0] : alu_res[W-1:0];
        if (cnt_r == '0) begin
          rem_nxt   = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = CNT_W'(W - 1);
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      // msb-first shift-add multiply with sticky overflow
      S_MUL: begin
        alu_a   = {1'b0, rem_r[W-2:0], 1'b0};
        alu_b   = a_r[W-1] ? {1'b0, b_r} : '0;
        alu_op  = ALU_ADD;
        rem_nxt = alu_res[W-1:0];
        ovf_nxt = ovf_step;
        a_nxt   = a_r << 1;
        if (cnt_r == '0) begin
          valid_nxt  = 1'b1;
          value_nxt  = ovf_step ? '0 : alu_res[W-1:0];
          status_nxt = ovf_step ? ST_OVERFLOW : ST_OK;
          state_nxt  = S_IDLE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      rem_r    <= rem_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign res_valid  = valid_r;
  assign res_value  = value_r;
  assign res_status = status_r;

endmodule

// ----- design/least_common_multiple_checked_top.sv -----
// least common multiple of two unsigned operands, with overflow check
// a transaction starts when start is high while busy is low; in_operand_a and
// in_operand_b are sampled at that edge, only their low OPERAND_WIDTH bits used
// busy stays high while the item is worked on; no new start is taken then
// the result appears on out_lcm_value / out_status for one cycle with out_valid
// status: 0 ok, 1 product overflows OPERAND_WIDTH bits, 2 second operand zero
// a zero operand gives its result in the cycle after start, busy never rising
// otherwise the item runs through one shared add/subtract unit:
//   strip common factors of two
//   binary gcd loop (shift, swap, subtract)
//   restoring division a/gcd, then shift-add multiply
// one item at a time; the next start may come in the cycle that carries
// out_valid
// the receiver cannot stall: out_valid is a one-cycle strobe
// synchronous reset returns the sequencer to idle and drops any item in flight
module least_common_multiple_checked_top #(
  parameter int OPERAND_WIDTH = lcmc_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [lcmc_pkg::FIELD_W-1:0]   in_operand_a,
  input  logic [lcmc_pkg::FIELD_W-1:0]   in_operand_b,
  output logic                           out_valid,
  output logic [lcmc_pkg::FIELD_W-1:0]   out_lcm_value,
  output logic [lcmc_pkg::STATUS_W-1:0]  out_status
);
  import lcmc_pkg::*;

  localparam int W = OPERAND_WIDTH;

  logic [W:0]   alu_a;
  logic [W:0]   alu_b;
  logic [W:0]   alu_res;
  alu_op_t      alu_op;
  logic [W-1:0] res_value;
  status_t      res_status;

  lcmc_ctrl #(
    .W (W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .opa        (in_operand_a[W-1:0]),
    .opb        (in_operand_b[W-1:0]),
    .busy       (busy),
    .res_valid  (out_valid),
    .res_value  (res_value),
    .res_status (res_status),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_op     (alu_op),
    .alu_res    (alu_res)
  );

  lcmc_addsub #(
    .W (W)
  ) u_addsub (
    .op_a (alu_a),
    .op_b (alu_b),
    .op   (alu_op),
    .res  (alu_res)
  );

  assign out_lcm_value = FIELD_W'(res_value);
  assign out_status    = res_status;

`ifndef ASSERT_OFF
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted transaction neither in progress nor answered");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_lcm_value == '0)
    else $error("nonzero value with error status");

  a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_OVERFLOW ||
                  out_status == ST_ZERO_B)
    else $error("undefined status code");
`endif

endmodule

// ----- test/least_common_multiple_checked_top_tb.sv -----
`timescale 1ns / 100ps

module least_common_multiple_checked_top_tb;
  import lcmc_pkg::*;

  localparam int OPW = OPERAND_WIDTH_DEF;
  localparam logic [FIELD_W-1:0] OPERAND_MASK = {FIELD_W{1'b1}} >> (FIELD_W - OPW);
  localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};
  localparam int N_RANDOM = 1300;
  localparam int DRAIN_CYCLES = 6 * OPW + 32;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic [FIELD_W-1:0] op_a;
    logic [FIELD_W-1:0] op_b;
    logic [FIELD_W-1:0] lcm;
    status_t status;
  } lcm_entry_t;

  class lcm_ledger;
    lcm_entry_t awaited[$];
    int error_count;

    function new();
      error_count = 0;
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
    endtask

    function lcm_entry_t predict_lcm(input logic [FIELD_W-1:0] a_in,
                                     input logic [FIELD_W-1:0] b_in);
      logic [FIELD_W-1:0] a, b, x, y, r, quo;
      logic [2*FIELD_W-1:0] prod;
      lcm_entry_t e;
      a = a_in & OPERAND_MASK;
      b = b_in & OPERAND_MASK;
      e.op_a = a_in;
      e.op_b = b_in;
      e.lcm = '0;
      e.status = ST_OK;
      if (b == '0) begin
        e.status = ST_ZERO_B;
      end else begin
        // euclid; a zero first operand leaves the divisor at b and the quotient at zero
        x = a;
        y = b;
        while (y != '0) begin
          r = x % y;
          x = y;
          y = r;
        end
        quo = a / x;
        prod = {{FIELD_W{1'b0}}, quo} * {{FIELD_W{1'b0}}, b};
        if (prod > {{FIELD_W{1'b0}}, OPERAND_MASK})
          e.status = ST_OVERFLOW;
        else
          e.lcm = prod[FIELD_W-1:0];
      end
      return e;
    endfunction

    function void note_operands(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
      awaited.insert(awaited.size(), predict_lcm(a, b));
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task check_lcm(input logic [FIELD_W-1:0] lcm, input logic [STATUS_W-1:0] status);
      lcm_entry_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result lcm=%h status=%0d", lcm, status));
      end else begin
        e = awaited.pop_front();
        if (status !== e.status)
          report($sformatf("status a=%h b=%h got %0d want %0d",
                           e.op_a, e.op_b, status, e.status));
        if (lcm !== e.lcm)
          report($sformatf("lcm a=%h b=%h got %h want %h",
                           e.op_a, e.op_b, lcm, e.lcm));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [FIELD_W-1:0] in_operand_a;
  logic [FIELD_W-1:0] in_operand_b;
  logic out_valid;
  logic [FIELD_W-1:0] out_lcm_value;
  logic [STATUS_W-1:0] out_status;

  int unsigned cycle_count = 0;
  lcm_ledger ledger = new();

  least_common_multiple_checked_top #(
    .OPERAND_WIDTH(OPW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid(out_valid),
    .out_lcm_value(out_lcm_value),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      ledger.check_lcm(out_lcm_value, out_status);
    end
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [FIELD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // holds start until the transaction is taken; start is left high for the caller
  task automatic send_item(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    start <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    ledger.note_operands(a, b);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic pick_operands(output logic [FIELD_W-1:0] a, output logic [FIELD_W-1:0] b);
    logic [FIELD_W-1:0] g;
    int s;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        a = rand64() >> (FIELD_W - $urandom_range(1, FIELD_W));
        b = rand64() >> (FIELD_W - $urandom_range(1, FIELD_W));
      end
      3, 4: begin
        // shared factor so the lcm tends to fit
        g = rand64() >> $urandom_range(32, 63);
        a = g * (rand64() >> $urandom_range(34, 63));
        b = g * (rand64() >> $urandom_range(34, 63));
      end
      5: begin
        a = rand64();
        b = rand64();
      end
      6: begin
        a = ($urandom_range(0, 1) == 0) ? '0 : rand64() >> $urandom_range(0, 63);
        b = ($urandom_range(0, 2) == 0) ? rand64() >> $urandom_range(0, 63) : '0;
        if (a != '0 && b != '0) a = '0;
      end
      7: begin
        a = ($urandom_range(0, 1) == 0) ? (64'd1 << $urandom_range(0, 63))
                                         : (ALL_ONES >> $urandom_range(0, 63));
        b = ($urandom_range(0, 1) == 0) ? (64'd1 << $urandom_range(0, 63))
                                         : (ALL_ONES >> $urandom_range(0, 63));
      end
      8: begin
        b = (rand64() >> $urandom_range(32, 63)) | 64'd1;
        a = b * (rand64() >> $urandom_range(40, 63));
        if ($urandom_range(0, 1) == 0) begin
          g = a;
          a = b;
          b = (g == '0) ? 64'd1 : g;
        end
      end
      default: begin
        // product straddles the top of the operand range
        s = $urandom_range(1, 63);
        a = rand64() >> s;
        b = (rand64() >> (FIELD_W - s)) | 64'd1;
      end
    endcase
  endtask

  initial begin
    logic [FIELD_W-1:0] dir_a[$];
    logic [FIELD_W-1:0] dir_b[$];
    logic [FIELD_W-1:0] a, b;
    int sent;
    int burst;
    int gap;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_operand_a <= '0;
    in_operand_b <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    dir_a = '{64'd0, 64'd0, 64'd5, ALL_ONES, 64'd0, 64'd1, ALL_ONES, ALL_ONES, 64'd1,
              ALL_ONES, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
              64'h1_0000_0000, 64'hFFFF_FFFF, 64'd6, 64'd12,
              64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
              64'hFFFF_FFFF_FFFF_FFC5, 64'd3, 64'h8000_0000_0000_0000,
              64'h0123_4567_89AB_CDEF};
    dir_b = '{64'd0, 64'd5, 64'd0, 64'd0, ALL_ONES, 64'd1, ALL_ONES, 64'd1, ALL_ONES,
              ALL_ONES - 64'd1, 64'd2, 64'd3,
              64'h1_0000_0001, 64'h1_0000_0001, 64'd4, 64'd18,
              64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
              64'd2, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
              64'hFEDC_BA98_7654_3210};
    foreach (dir_a[i]) send_item(dir_a[i], dir_b[i]);
    wait_drained();

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
        pick_operands(a, b);
        send_item(a, b);
        sent++;
      end
      if ($urandom_range(0, 40) == 0) begin
        wait_drained();
      end else begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3: gap = 0;
          4: gap = $urandom_range(1, 450);
          default: gap = $urandom_range(1, 12);
        endcase
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_drained();
    // room for any stray strobe after the last expected result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
design/lcmc_pkg.sv
design/lcmc_addsub.sv
design/lcmc_ctrl.sv
design/least_common_multiple_checked_top.sv
test/least_common_multiple_checked_top_tb.sv
